### hdl/cfs_pkg.sv
// Shared types and constants for the cube map face selector.
package cfs_pkg;

  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  // Control that travels with a word down the divider chain.
  typedef struct packed {
    logic       valid;
    logic [2:0] face;
    logic       zero;
    logic       u_neg;
    logic       v_neg;
  } tag_t;

endpackage

### hdl/cfs_ifs.sv
// Valid/ready channels for direction words and face words.
interface cfs_dir_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] dir_x;
  logic signed [W-1:0] dir_y;
  logic signed [W-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cfs_face_if #(
  parameter int CW = 16
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           face_index;
  logic signed [CW-1:0] coord_u;
  logic signed [CW-1:0] coord_v;
  logic                 zero_vector;

  modport source (output valid, output face_index, output coord_u, output coord_v,
                  output zero_vector, input ready);
  modport sink   (input valid, input face_index, input coord_u, input coord_v,
                  input zero_vector, output ready);
endinterface

### hdl/cfs_select.sv
// Front stage: major axis pick, face code, sign flips and magnitudes.
module cfs_select #(
  parameter int C = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  logic signed [C-1:0] dir_x,
  input  logic signed [C-1:0] dir_y,
  input  logic signed [C-1:0] dir_z,
  output cfs_pkg::tag_t       tag,
  output logic [C-1:0]        ma,
  output logic [C-1:0]        u_mag,
  output logic [C-1:0]        v_mag
);

  logic          sx, sy, sz;
  logic [C-1:0]  ax, ay, az;
  logic [C-1:0]  ma_next, u_mag_next, v_mag_next;
  cfs_pkg::tag_t tag_next;

  always_comb begin
    sx = dir_x[C-1];
    sy = dir_y[C-1];
    sz = dir_z[C-1];
    // exact magnitude, most negative value included
    ax = sx ? (~unsigned'(dir_x) + 1'b1) : unsigned'(dir_x);
    ay = sy ? (~unsigned'(dir_y) + 1'b1) : unsigned'(dir_y);
    az = sz ? (~unsigned'(dir_z) + 1'b1) : unsigned'(dir_z);

    tag_next       = '0;
    tag_next.valid = valid_in;
    priority if (ax >= ay && ax >= az) begin
      ma_next    = ax;
      u_mag_next = az;
      v_mag_next = ay;
      tag_next.v_neg = ~sy;
      if (!sx && ax != '0) begin
        tag_next.face  = cfs_pkg::FACE_POS_X;
        tag_next.u_neg = ~sz;
      end else begin
        tag_next.face  = cfs_pkg::FACE_NEG_X;
        tag_next.u_neg = sz;
      end
    end else if (ay > ax && ay >= az) begin
      ma_next    = ay;
      u_mag_next = ax;
      v_mag_next = az;
      tag_next.u_neg = sx;
      if (!sy) begin
        tag_next.face  = cfs_pkg::FACE_POS_Y;
        tag_next.v_neg = sz;
      end else begin
        tag_next.face  = cfs_pkg::FACE_NEG_Y;
        tag_next.v_neg = ~sz;
      end
    end else begin
      ma_next    = az;
      u_mag_next = ax;
      v_mag_next = ay;
      tag_next.v_neg = ~sy;
      if (!sz) begin
        tag_next.face  = cfs_pkg::FACE_POS_Z;
        tag_next.u_neg = sx;
      end else begin
        tag_next.face  = cfs_pkg::FACE_NEG_Z;
        tag_next.u_neg = ~sx;
      end
    end
    tag_next.zero = (ma_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else if (en) begin
      tag.valid <= tag_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag.face  <= tag_next.face;
      tag.zero  <= tag_next.zero;
      tag.u_neg <= tag_next.u_neg;
      tag.v_neg <= tag_next.v_neg;
      ma        <= ma_next;
      u_mag     <= u_mag_next;
      v_mag     <= v_mag_next;
    end
  end

endmodule

### hdl/cfs_div_cell.sv
// One divider cell: one quotient bit for both face coordinates.
module cfs_div_cell #(
  parameter int C      = 16,
  parameter int QW     = 16,
  parameter bit DOUBLE = 1'b1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  cfs_pkg::tag_t  tag_in,
  input  logic [C-1:0]   ma_in,
  input  logic [C-1:0]   ru_in,
  input  logic [C-1:0]   rv_in,
  input  logic [QW-1:0]  qu_in,
  input  logic [QW-1:0]  qv_in,
  output cfs_pkg::tag_t  tag_out,
  output logic [C-1:0]   ma_out,
  output logic [C-1:0]   ru_out,
  output logic [C-1:0]   rv_out,
  output logic [QW-1:0]  qu_out,
  output logic [QW-1:0]  qv_out
);

  logic [C-1:0] du, dv;
  logic         bu, bv;

  // Past the first cell the remainder stays below ma, so its top bit is clear.
  always_comb begin
    du = DOUBLE ? {ru_in[C-2:0], 1'b0} : ru_in;
    dv = DOUBLE ? {rv_in[C-2:0], 1'b0} : rv_in;
    bu = (du >= ma_in);
    bv = (dv >= ma_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else if (en) begin
      tag_out.valid <= tag_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_out.face  <= tag_in.face;
      tag_out.zero  <= tag_in.zero;
      tag_out.u_neg <= tag_in.u_neg;
      tag_out.v_neg <= tag_in.v_neg;
      ma_out        <= ma_in;
      ru_out        <= bu ? (du - ma_in) : du;
      rv_out        <= bv ? (dv - ma_in) : dv;
      qu_out        <= {qu_in[QW-2:0], bu};
      qv_out        <= {qv_in[QW-2:0], bv};
    end
  end

endmodule

### hdl/cubemap_face_select.sv
// Cube map face selector: major axis pick and face coordinate divider chain.
//
// Takes one direction word (dir_x, dir_y, dir_z, signed) per cycle and returns
// one face word per cycle: the face 0..5 (+X, -X, +Y, -Y, +Z, -Z) of the axis
// with the largest magnitude (ties go to x, then y), and the two remaining
// components, sign-flipped per the usual cube map face table and divided by
// the major magnitude, as signed fixed point with FRACTION_BITS fraction bits,
// rounded to nearest with ties away from zero. An all-zero direction sets
// zero_vector, gives face -X and zero coordinates. Throughput is one word per
// cycle. A word passes through the face pick register, then a chain of
// FRACTION_BITS + 2 restoring-divider cells that each resolve one bit of both
// coordinates, then rounding into the output register. A two-entry output
// (register plus skid) lets the chain keep accepting while a finished word
// waits; the input stalls only once both entries are full.
module cubemap_face_select #(
  parameter int COMPONENT_BITS = 16,
  parameter int FRACTION_BITS  = 14
) (
  input logic       clk,
  input logic       rst,
  cfs_dir_if.sink   dir_in,
  cfs_face_if.source face_out
);

  localparam int C  = COMPONENT_BITS;
  localparam int QW = FRACTION_BITS + 2;   // quotient bits, also coordinate width

  // Chain taps: index 0 is the face-pick register, index QW the last cell.
  cfs_pkg::tag_t   tag_c [0:QW];
  logic [C-1:0]    ma_c  [0:QW];
  logic [C-1:0]    ru_c  [0:QW];
  logic [C-1:0]    rv_c  [0:QW];
  logic [QW-1:0]   qu_c  [0:QW];
  logic [QW-1:0]   qv_c  [0:QW];

  logic            en;
  logic            take_out;

  // Output register and skid entry.
  logic            out_valid;
  logic [2:0]      out_face;
  logic [QW-1:0]   out_u;
  logic [QW-1:0]   out_v;
  logic            out_zero;
  logic            skid_valid;
  logic [2:0]      skid_face;
  logic [QW-1:0]   skid_u;
  logic [QW-1:0]   skid_v;
  logic            skid_zero;

  // Word leaving the chain after rounding and sign.
  logic [QW:0]     sum_u, sum_v;
  logic [QW-1:0]   mag_u, mag_v;
  logic [QW-1:0]   w_u, w_v;

  // Advance the whole chain unless the skid entry is occupied.
  assign en            = ~skid_valid;
  assign dir_in.ready  = en;
  assign take_out      = out_valid & face_out.ready;

  cfs_select #(.C(C)) u_select (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (dir_in.valid),
    .dir_x    (dir_in.dir_x),
    .dir_y    (dir_in.dir_y),
    .dir_z    (dir_in.dir_z),
    .tag      (tag_c[0]),
    .ma       (ma_c[0]),
    .u_mag    (ru_c[0]),
    .v_mag    (rv_c[0])
  );

  assign qu_c[0] = '0;
  assign qv_c[0] = '0;

  // One cell per quotient bit; the first cell compares without doubling
  // because the numerator never exceeds the major magnitude.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    cfs_div_cell #(.C(C), .QW(QW), .DOUBLE(i != 0)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .tag_in  (tag_c[i]),
      .ma_in   (ma_c[i]),
      .ru_in   (ru_c[i]),
      .rv_in   (rv_c[i]),
      .qu_in   (qu_c[i]),
      .qv_in   (qv_c[i]),
      .tag_out (tag_c[i+1]),
      .ma_out  (ma_c[i+1]),
      .ru_out  (ru_c[i+1]),
      .rv_out  (rv_c[i+1]),
      .qu_out  (qu_c[i+1]),
      .qv_out  (qv_c[i+1])
    );
  end

  // The chain yields floor(2 * n * 2^F / ma); add one and halve to round.
  always_comb begin
    sum_u = {1'b0, qu_c[QW]} + 1'b1;
    sum_v = {1'b0, qv_c[QW]} + 1'b1;
    mag_u = sum_u[QW:1];
    mag_v = sum_v[QW:1];
    if (tag_c[QW].zero) begin
      w_u = '0;
      w_v = '0;
    end else begin
      w_u = tag_c[QW].u_neg ? (~mag_u + 1'b1) : mag_u;
      w_v = tag_c[QW].v_neg ? (~mag_v + 1'b1) : mag_v;
    end
  end

  // Drain the skid first; otherwise land the chain word in the output
  // register when it is free, else park it in the skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (take_out) begin
          skid_valid <= 1'b0;
        end
      end else if (tag_c[QW].valid) begin
        if (!out_valid || take_out) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (take_out) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take_out) begin
        out_face <= skid_face;
        out_u    <= skid_u;
        out_v    <= skid_v;
        out_zero <= skid_zero;
      end
    end else if (tag_c[QW].valid) begin
      if (!out_valid || take_out) begin
        out_face <= tag_c[QW].face;
        out_u    <= w_u;
        out_v    <= w_v;
        out_zero <= tag_c[QW].zero;
      end else begin
        skid_face <= tag_c[QW].face;
        skid_u    <= w_u;
        skid_v    <= w_v;
        skid_zero <= tag_c[QW].zero;
      end
    end
  end

  assign face_out.valid       = out_valid;
  assign face_out.face_index  = out_face;
  assign face_out.coord_u     = signed'(out_u);
  assign face_out.coord_v     = signed'(out_v);
  assign face_out.zero_vector = out_zero;

  localparam logic signed [QW-1:0] ONE = QW'(1) <<< FRACTION_BITS;

  // Skid holds a word only behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while output register empty");

  // A parked word stays parked until the output word is taken.
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !take_out) |=> skid_valid)
    else $error("skid entry dropped without a take");

  // Zero vector gives face -X and zero coordinates.
  a_zero_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_zero) |->
      (out_face == cfs_pkg::FACE_NEG_X && out_u == '0 && out_v == '0))
    else $error("zero vector word malformed");

  // Coordinates stay within [-1, 1].
  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (signed'(out_u) <= ONE && signed'(out_u) >= -ONE &&
                   signed'(out_v) <= ONE && signed'(out_v) >= -ONE))
    else $error("face coordinate outside unit range");

endmodule
